// ===== hw/rtl/tdvl_pkg.sv =====
// Shared types, constants and helpers of the tabular TD value learner.
`default_nettype none
package tdvl_pkg;
	localparam int STATES    = 16;
	localparam int SIDX_W    = $clog2(STATES);
	localparam int CELL_W    = 3 * SIDX_W;
	localparam int COUNT_W   = 16;
	localparam int TOTAL_W   = COUNT_W + SIDX_W;
	localparam int CFG_IDX_W = 8;

	localparam logic [1:0] CMD_LEARN   = 2'd0;
	localparam logic [1:0] CMD_REBUILD = 2'd1;
	localparam logic [1:0] CMD_SELECT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT       = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_LEVEL  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PROB_THRESHOLD = 8'd3;

	typedef struct packed {
		logic [1:0]        command;
		logic [3:0]        state_index;
		logic [3:0]        action_taken;
		logic signed [31:0] reward;
		logic [3:0]        next_state_index;
		logic [15:0]       random_draw;
		logic [3:0]        random_action;
	} request_t;

	typedef struct packed {
		logic [3:0] chosen_action;
		logic       explored;
		logic       found;
	} result_t;

	function automatic logic [CELL_W-1:0] cell_addr(input logic [SIDX_W-1:0] s,
		input logic [SIDX_W-1:0] n, input logic [SIDX_W-1:0] a);
		return {s, n, a};
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/tabular_td_value_learner_unit.sv =====
// Top level of the tabular TD value learner: tables, sequencer and command datapath.
`default_nettype none
//  channel   direction  handshake             payload
//  request   in         start && !busy        tdvl_pkg::request_t
//  result    out        result_valid strobe   tdvl_pkg::result_t
//  config    in         cfg_valid && cfg_ready cfg_index, cfg_data
//
// After reset a clearing pass over all 4096 cells zeroes the count and
// probability memories; busy stays high during it. A learn request runs
// through the memory read, two multiplies and the write back. A select that
// explores, and the unused command, answer in the cycle after the request is
// taken; a greedy select visits ranked states in turn, with one probability
// memory read per action. A rebuild uses the one-bit-per-cycle divider.
// Results are strobed for one cycle and cannot be stalled.
module tabular_td_value_learner_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire tdvl_pkg::request_t          request,
	output logic                             result_valid,
	output tdvl_pkg::result_t                result,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [tdvl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                 cfg_data
);
	import tdvl_pkg::*;

	// Sequencer state codes.
	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_L1   = 4'd2;
	localparam logic [3:0] ST_L2   = 4'd3;
	localparam logic [3:0] ST_L3   = 4'd4;
	localparam logic [3:0] ST_L4   = 4'd5;
	localparam logic [3:0] ST_RS   = 4'd6;
	localparam logic [3:0] ST_RA   = 4'd7;
	localparam logic [3:0] ST_RB   = 4'd8;
	localparam logic [3:0] ST_RC   = 4'd9;
	localparam logic [3:0] ST_K    = 4'd10;
	localparam logic [3:0] ST_SR   = 4'd11;
	localparam logic [3:0] ST_SP   = 4'd12;

	localparam logic signed [36:0] VMAX = 37'sd2147483647;
	localparam logic signed [36:0] VMIN = -37'sd2147483648;
	localparam int CUBE = STATES * STATES * STATES;

	logic [3:0] state_q;

	// Configuration registers.
	logic [15:0] lr_q, disc_q, eps_q, thr_q;

	// Memories: value table (two read ports), ranking, counts, probabilities.
	logic signed [31:0] vmem [STATES];
	logic [STATES-1:0]  vvalid_q;
	logic [SIDX_W-1:0]  rkmem [STATES];
	logic [STATES-1:0]  rkvalid_q;
	logic [COUNT_W-1:0] cmem [CUBE];
	logic [15:0]        pmem [CUBE];

	logic [SIDX_W-1:0]  v_ra0, v_ra1, rk_ra;
	logic signed [31:0] v_rd0_q, v_rd1_q;
	logic               v_rv0_q, v_rv1_q;
	logic signed [31:0] val0, val1;
	logic [SIDX_W-1:0]  rk_rd_q, rk_ra_q;
	logic               rk_rv_q;
	logic [SIDX_W-1:0]  rank_val;
	logic [CELL_W-1:0]  c_ra, p_ra, c_wa, p_wa;
	logic               c_we, p_we;
	logic [COUNT_W-1:0] c_wd, c_rd_q;
	logic [15:0]        p_wd, p_rd_q;

	// Working registers.
	request_t           item_q;
	logic [CELL_W-1:0]  clr_q;
	logic signed [31:0] vs_q;
	logic signed [48:0] prod1_q;
	logic signed [34:0] t_q;
	logic signed [51:0] prod2_q;
	logic [7:0]         sa_q;
	logic [4:0]         n_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W:0]   rem_q;
	logic [15:0]        quo_q;
	logic [3:0]         bit_q;
	logic [SIDX_W-1:0]  i_q, pos_q, r_q, o_q, best_q;
	logic [4:0]         k_q;
	logic [15:0]        bestp_q;
	logic               res_valid_q;
	result_t            res_q;

	// Combinational helpers.
	logic signed [34:0] t_next;
	logic signed [36:0] nv;
	logic signed [31:0] vnew;
	logic [TOTAL_W:0]   rem2;
	logic               ge;
	logic [15:0]        qfinal;
	logic               beats;
	logic [SIDX_W-1:0]  kk, nbest;
	logic [15:0]        nbestp;
	logic               take;
	logic [SIDX_W-1:0]  cur_s, cur_a, cur_n;

	assign cfg_ready    = 1'b1;
	assign busy         = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign cur_s = sa_q[7:4];
	assign cur_a = sa_q[3:0];
	assign cur_n = n_q[SIDX_W-1:0];

	assign val0     = v_rv0_q ? v_rd0_q : 32'sd0;
	assign val1     = v_rv1_q ? v_rd1_q : 32'sd0;
	assign rank_val = rk_rv_q ? rk_rd_q : rk_ra_q;

	// TD arithmetic: floor by arithmetic shift, then saturate the new value.
	assign t_next = 35'(item_q.reward) + 35'($signed(prod1_q[48:16])) - 35'(vs_q);
	assign nv     = 37'(vs_q) + 37'($signed(prod2_q[51:16]));
	always_comb begin
		if (nv > VMAX) begin
			vnew = 32'sh7FFFFFFF;
		end else if (nv < VMIN) begin
			vnew = 32'sh80000000;
		end else begin
			vnew = nv[31:0];
		end
	end

	// Restoring divider step; the remainder always stays below the total.
	assign rem2   = {rem_q[TOTAL_W-1:0], 1'b0};
	assign ge     = (rem2 >= {1'b0, total_q});
	assign qfinal = {quo_q[14:0], ge};

	// Ranking: state j outranks state i if larger, or equal with lower index.
	assign beats = (val1 > val0) || ((val1 == val0) && (kk < i_q));

	// Argmax scan over actions, first index wins ties.
	assign kk     = SIDX_W'(k_q - 5'd1);
	assign take   = (k_q == 5'd1) || (p_rd_q > bestp_q);
	assign nbest  = take ? kk : best_q;
	assign nbestp = take ? p_rd_q : bestp_q;

	// Read addresses.
	always_comb begin
		v_ra0 = '0;
		v_ra1 = '0;
		c_ra  = '0;
		p_ra  = '0;
		rk_ra = '0;
		unique case (state_q)
			ST_IDLE: begin
				v_ra0 = request.state_index[SIDX_W-1:0];
				v_ra1 = request.next_state_index[SIDX_W-1:0];
				c_ra  = cell_addr(request.state_index[SIDX_W-1:0],
					request.next_state_index[SIDX_W-1:0],
					request.action_taken[SIDX_W-1:0]);
			end
			ST_RS, ST_RA: c_ra = cell_addr(cur_s, cur_n, cur_a);
			ST_K: begin
				v_ra0 = i_q;
				v_ra1 = SIDX_W'(k_q);
			end
			ST_SP: begin
				p_ra  = cell_addr(item_q.state_index[SIDX_W-1:0], o_q, SIDX_W'(k_q));
				rk_ra = SIDX_W'(r_q + 1'b1);
			end
			default: ;
		endcase
	end

	// Write ports of the count and probability memories.
	always_comb begin
		c_we = 1'b0;
		c_wa = clr_q;
		c_wd = '0;
		p_we = 1'b0;
		p_wa = cell_addr(cur_s, cur_n, cur_a);
		p_wd = '0;
		unique case (state_q)
			ST_CLR: begin
				c_we = 1'b1;
				p_we = 1'b1;
				p_wa = clr_q;
			end
			ST_L1: begin
				c_we = 1'b1;
				c_wa = cell_addr(item_q.state_index[SIDX_W-1:0],
					item_q.next_state_index[SIDX_W-1:0],
					item_q.action_taken[SIDX_W-1:0]);
				c_wd = (c_rd_q == '1) ? c_rd_q : c_rd_q + 1'b1;
			end
			ST_RB: begin
				if (total_q == '0) begin
					p_we = 1'b1;
				end else if (TOTAL_W'(c_rd_q) == total_q) begin
					p_we = 1'b1;
					p_wd = 16'hFFFF;
				end
			end
			ST_RC: begin
				p_we = (bit_q == 4'd15);
				p_wd = qfinal;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (c_we) begin
			cmem[c_wa] <= c_wd;
		end
		c_rd_q <= cmem[c_ra];
		if (p_we) begin
			pmem[p_wa] <= p_wd;
		end
		p_rd_q <= pmem[p_ra];
		if (state_q == ST_L4) begin
			vmem[item_q.state_index[SIDX_W-1:0]] <= vnew;
		end
		v_rd0_q <= vmem[v_ra0];
		v_rd1_q <= vmem[v_ra1];
		if (state_q == ST_K && k_q == 5'(STATES)) begin
			rkmem[pos_q + SIDX_W'(beats)] <= i_q;
		end
		rk_rd_q <= rkmem[rk_ra];
		rk_ra_q <= rk_ra;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vvalid_q  <= '0;
			rkvalid_q <= '0;
			v_rv0_q   <= 1'b0;
			v_rv1_q   <= 1'b0;
			rk_rv_q   <= 1'b0;
		end else begin
			if (state_q == ST_L4) begin
				vvalid_q[item_q.state_index[SIDX_W-1:0]] <= 1'b1;
			end
			if (state_q == ST_K && k_q == 5'(STATES)) begin
				rkvalid_q[pos_q + SIDX_W'(beats)] <= 1'b1;
			end
			v_rv0_q <= vvalid_q[v_ra0];
			v_rv1_q <= vvalid_q[v_ra1];
			rk_rv_q <= rkvalid_q[rk_ra];
		end
	end

	// Configuration writes; indexes past the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= 16'd6554;
			disc_q <= 16'd58982;
			eps_q  <= 16'd6554;
			thr_q  <= 16'd655;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LEARNING_RATE:  lr_q   <= cfg_data;
				CFG_DISCOUNT:       disc_q <= cfg_data;
				CFG_EXPLORE_LEVEL:  eps_q  <= cfg_data;
				CFG_PROB_THRESHOLD: thr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			item_q <= request;
		end
		unique case (state_q)
			ST_L1: begin
				vs_q    <= val0;
				prod1_q <= $signed({1'b0, disc_q}) * val1;
			end
			ST_L2: t_q <= t_next;
			ST_L3: prod2_q <= $signed({1'b0, lr_q}) * t_q;
			ST_RB: begin
				rem_q <= (TOTAL_W + 1)'(c_rd_q);
				quo_q <= '0;
			end
			ST_RC: begin
				rem_q <= ge ? rem2 - {1'b0, total_q} : rem2;
				quo_q <= qfinal;
			end
			ST_SR: begin
				o_q     <= rank_val;
				best_q  <= '0;
				bestp_q <= '0;
			end
			ST_SP: begin
				if (k_q != 5'd0) begin
					best_q  <= nbest;
					bestp_q <= nbestp;
				end
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			sa_q        <= '0;
			n_q         <= '0;
			total_q     <= '0;
			bit_q       <= '0;
			i_q         <= '0;
			pos_q       <= '0;
			k_q         <= '0;
			r_q         <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			res_q       <= '0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						unique case (request.command)
							CMD_LEARN: state_q <= ST_L1;
							CMD_REBUILD: begin
								state_q <= ST_RS;
								sa_q    <= '0;
								n_q     <= '0;
								total_q <= '0;
							end
							CMD_SELECT: begin
								if (eps_q >= request.random_draw) begin
									res_valid_q         <= 1'b1;
									res_q.chosen_action <= request.random_action;
									res_q.explored      <= 1'b1;
								end else begin
									state_q <= ST_SR;
									r_q     <= '0;
								end
							end
							default: res_valid_q <= 1'b1;
						endcase
					end
				end
				ST_L1: state_q <= ST_L2;
				ST_L2: state_q <= ST_L3;
				ST_L3: state_q <= ST_L4;
				ST_L4: begin
					state_q     <= ST_IDLE;
					res_valid_q <= 1'b1;
				end
				ST_RS: begin
					// Count data comes from the registered read, so it belongs to the previous next-state.
					if (n_q != 5'd0) begin
						total_q <= total_q + TOTAL_W'(c_rd_q);
					end
					if (n_q == 5'(STATES)) begin
						n_q     <= '0;
						state_q <= ST_RA;
					end else begin
						n_q <= n_q + 1'b1;
					end
				end
				ST_RA: state_q <= ST_RB;
				ST_RB, ST_RC: begin
					if (state_q == ST_RB && !p_we) begin
						state_q <= ST_RC;
						bit_q   <= '0;
					end else if (state_q == ST_RC && !p_we) begin
						bit_q <= bit_q + 1'b1;
					end else if (cur_n == SIDX_W'(STATES - 1)) begin
						n_q <= '0;
						if (sa_q == '1) begin
							state_q <= ST_K;
							i_q     <= '0;
							k_q     <= '0;
							pos_q   <= '0;
						end else begin
							sa_q    <= sa_q + 1'b1;
							total_q <= '0;
							state_q <= ST_RS;
						end
					end else begin
						n_q     <= n_q + 1'b1;
						state_q <= ST_RA;
					end
				end
				ST_K: begin
					if (k_q != 5'd0 && k_q != 5'(STATES)) begin
						pos_q <= pos_q + SIDX_W'(beats);
					end
					if (k_q == 5'(STATES)) begin
						k_q   <= '0;
						pos_q <= '0;
						i_q   <= i_q + 1'b1;
						if (i_q == SIDX_W'(STATES - 1)) begin
							state_q     <= ST_IDLE;
							res_valid_q <= 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_SR: begin
					state_q <= ST_SP;
					k_q     <= '0;
				end
				ST_SP: begin
					if (k_q == 5'(STATES)) begin
						if (nbestp > thr_q || r_q == SIDX_W'(STATES - 1)) begin
							state_q             <= ST_IDLE;
							res_valid_q         <= 1'b1;
							res_q.chosen_action <= 4'(nbest);
							res_q.found         <= (nbestp > thr_q);
						end else begin
							r_q     <= r_q + 1'b1;
							state_q <= ST_SR;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// An explored result never claims a greedy hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.explored) |-> !result.found)
		else $error("explored result marked found");

	// Every accepted request either occupies the unit or answers at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || result_valid))
		else $error("request neither started nor answered");

	// The learn write-back cycle always produces its result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_L4) |=> (result_valid && !busy))
		else $error("learn finished without result");

	// No result appears while the clearing pass runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |=> (!result_valid))
		else $error("result during clearing pass");
endmodule
`default_nettype wire
